// ----- hw/rtl/alle_pkg.sv -----
package alle_pkg;

    typedef enum logic [3:0] {
        ACT_INS_FRONT = 4'd0,
        ACT_INS_REAR  = 4'd1,
        ACT_RM_FRONT  = 4'd2,
        ACT_RM_REAR   = 4'd3,
        ACT_RM_CUR    = 4'd4,
        ACT_SEARCH    = 4'd5,
        ACT_RETRIEVE  = 4'd6,
        ACT_PURGE     = 4'd7,
        ACT_CLEAR     = 4'd8,
        ACT_READ_CUR  = 4'd9
    } act_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOCUR = 2'd3
    } status_t;

    // Datapath micro-operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_ALLOC_FREE,
        OP_POP,
        OP_ALLOC_HW,
        OP_INS_WR_FRONT,
        OP_INS_WR_REAR,
        OP_PRIME,
        OP_STEP,
        OP_ATTACH,
        OP_RF,
        OP_RR_END,
        OP_RC_RD,
        OP_RC_LINK,
        OP_FOUND,
        OP_RES,
        OP_RES_CUR,
        OP_PG_START,
        OP_PG_KEY,
        OP_PG_DROP,
        OP_PG_KEEP,
        OP_PG_RDS,
        OP_PG_ADV,
        OP_PG_END,
        OP_CLR_END,
        OP_FETCH,
        OP_FETCH_Q,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t st;
    } cmd_t;

    typedef struct packed {
        logic head_zero;
        logic cur_zero;
        logic p_zero;
        logic pre_zero;
        logic link_zero;
        logic link_is_cur;
        logic cur_is_head;
        logic same;
        logic pos_zero;
        logic fh_zero;
        logic hw_full;
    } flags_t;

endpackage

// ----- hw/rtl/alle_dpath.sv -----
module alle_dpath #(
    parameter int NODES     = 256,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alle_pkg::cmd_t       cmd,
    output alle_pkg::flags_t     flags,
    input  logic [DATA_BITS-1:0] data_in,
    input  logic [7:0]           position,
    input  logic                 cfg_write,
    input  logic [DATA_BITS-1:0] cfg_data,
    output logic [1:0]           status,
    output logic [7:0]           node_index,
    output logic [DATA_BITS-1:0] data_out
);

    localparam int IW = $clog2(NODES);
    localparam logic [IW-1:0] LAST = IW'(NODES - 1);

    logic [DATA_BITS-1:0] pay_mem [NODES];
    logic [IW-1:0]        link_mem [NODES];
    logic [IW-1:0]        free_mem [NODES];

    logic [IW-1:0]        head_reg, cur_reg, hw_reg, fh_reg;
    logic [DATA_BITS-1:0] mask_reg;
    logic [IW-1:0]        s_reg, p_reg, pre_reg, nx_reg;
    logic [DATA_BITS-1:0] key_reg;
    logic [7:0]           pos_reg;
    alle_pkg::status_t    res_st_reg, out_st_reg;
    logic [IW-1:0]        res_idx_reg, out_idx_reg;
    logic [DATA_BITS-1:0] res_data_reg, out_data_reg;

    logic [DATA_BITS-1:0] pay_q;
    logic [IW-1:0]        link_q, flq;
    logic [IW-1:0]        raddr;

    logic                 link_we, pay_we, free_we;
    logic [IW-1:0]        link_wa, link_wd, pay_wa, free_wa;

    always_comb
    begin
        unique case (cmd.op)
            alle_pkg::OP_PRIME, alle_pkg::OP_PG_START: raddr = head_reg;
            alle_pkg::OP_STEP, alle_pkg::OP_PG_KEY, alle_pkg::OP_PG_DROP,
            alle_pkg::OP_PG_KEEP, alle_pkg::OP_PG_ADV:  raddr = link_q;
            alle_pkg::OP_RC_RD:                         raddr = cur_reg;
            alle_pkg::OP_PG_RDS:                        raddr = s_reg;
            alle_pkg::OP_FETCH:                         raddr = res_idx_reg;
            default:                                    raddr = p_reg;
        endcase
    end

    always_comb
    begin
        link_we = 1'b0;
        link_wa = p_reg;
        link_wd = '0;
        pay_we  = 1'b0;
        pay_wa  = s_reg;
        free_we = 1'b0;
        free_wa = head_reg;
        unique case (cmd.op)
            alle_pkg::OP_INS_WR_FRONT:
            begin
                link_we = 1'b1;
                link_wa = s_reg;
                link_wd = head_reg;
                pay_we  = 1'b1;
            end
            alle_pkg::OP_INS_WR_REAR:
            begin
                link_we = 1'b1;
                link_wa = s_reg;
                pay_we  = 1'b1;
            end
            alle_pkg::OP_ATTACH:
            begin
                link_we = 1'b1;
                link_wd = s_reg;
            end
            alle_pkg::OP_RF:
            begin
                free_we = 1'b1;
            end
            alle_pkg::OP_RR_END:
            begin
                link_we = 1'b1;
                link_wa = pre_reg;
                free_we = 1'b1;
                free_wa = p_reg;
            end
            alle_pkg::OP_RC_LINK:
            begin
                link_we = 1'b1;
                link_wd = link_q;
                free_we = 1'b1;
                free_wa = cur_reg;
            end
            alle_pkg::OP_PG_DROP:
            begin
                link_we = 1'b1;
                link_wd = link_q;
                free_we = 1'b1;
                free_wa = nx_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_q <= link_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_wa] <= key_reg;
        end
        pay_q <= pay_mem[raddr];
    end

    // freed slot is pushed on the free stack
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_wa] <= fh_reg;
        end
        flq <= free_mem[fh_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cur_reg  <= '0;
            hw_reg   <= '0;
            fh_reg   <= '0;
            mask_reg <= '1;
        end
        else
        begin
            if (cfg_write)
            begin
                mask_reg <= cfg_data;
            end
            unique case (cmd.op)
                alle_pkg::OP_ALLOC_HW:     hw_reg <= hw_reg + 1'b1;
                alle_pkg::OP_POP:          fh_reg <= flq;
                alle_pkg::OP_INS_WR_FRONT:
                begin
                    head_reg <= s_reg;
                    cur_reg  <= s_reg;
                end
                alle_pkg::OP_ATTACH:       cur_reg <= s_reg;
                alle_pkg::OP_RF:
                begin
                    fh_reg   <= head_reg;
                    head_reg <= link_q;
                    cur_reg  <= link_q;
                end
                alle_pkg::OP_RR_END:
                begin
                    fh_reg  <= p_reg;
                    cur_reg <= pre_reg;
                end
                alle_pkg::OP_RC_LINK:
                begin
                    fh_reg  <= cur_reg;
                    cur_reg <= p_reg;
                end
                alle_pkg::OP_FOUND:        cur_reg <= p_reg;
                alle_pkg::OP_PG_DROP:      fh_reg  <= nx_reg;
                alle_pkg::OP_PG_END:       cur_reg <= head_reg;
                alle_pkg::OP_CLR_END:      cur_reg <= '0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            alle_pkg::OP_LATCH:
            begin
                key_reg <= data_in;
                pos_reg <= position;
            end
            alle_pkg::OP_ALLOC_FREE: s_reg <= fh_reg;
            alle_pkg::OP_ALLOC_HW:   s_reg <= hw_reg + 1'b1;
            alle_pkg::OP_INS_WR_FRONT, alle_pkg::OP_ATTACH:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= s_reg;
            end
            alle_pkg::OP_PRIME:
            begin
                p_reg   <= head_reg;
                pre_reg <= '0;
            end
            alle_pkg::OP_STEP:
            begin
                pre_reg <= p_reg;
                p_reg   <= link_q;
                pos_reg <= pos_reg - 1'b1;
            end
            alle_pkg::OP_RF:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= link_q;
            end
            alle_pkg::OP_RR_END:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= pre_reg;
            end
            alle_pkg::OP_RC_LINK, alle_pkg::OP_FOUND:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= p_reg;
            end
            alle_pkg::OP_RES:
            begin
                res_st_reg  <= cmd.st;
                res_idx_reg <= '0;
            end
            alle_pkg::OP_RES_CUR:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= cur_reg;
            end
            alle_pkg::OP_PG_START:   s_reg <= head_reg;
            alle_pkg::OP_PG_KEY:
            begin
                key_reg <= pay_q;
                p_reg   <= s_reg;
                nx_reg  <= link_q;
            end
            alle_pkg::OP_PG_DROP:    nx_reg <= link_q;
            alle_pkg::OP_PG_KEEP:
            begin
                p_reg  <= nx_reg;
                nx_reg <= link_q;
            end
            alle_pkg::OP_PG_ADV:     s_reg <= link_q;
            alle_pkg::OP_PG_END:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= head_reg;
            end
            alle_pkg::OP_CLR_END:
            begin
                res_st_reg  <= alle_pkg::ST_OK;
                res_idx_reg <= '0;
            end
            alle_pkg::OP_FETCH_Q:
            begin
                res_data_reg <= (res_idx_reg == '0) ? '0 : pay_q;
            end
            alle_pkg::OP_OUT:
            begin
                out_st_reg   <= res_st_reg;
                out_idx_reg  <= res_idx_reg;
                out_data_reg <= res_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.head_zero   = (head_reg == '0);
        flags.cur_zero    = (cur_reg == '0);
        flags.p_zero      = (p_reg == '0);
        flags.pre_zero    = (pre_reg == '0);
        flags.link_zero   = (link_q == '0);
        flags.link_is_cur = (link_q == cur_reg);
        flags.cur_is_head = (cur_reg == head_reg);
        flags.same        = (((pay_q ^ key_reg) & mask_reg) == '0);
        flags.pos_zero    = (pos_reg == 8'd0);
        flags.fh_zero     = (fh_reg == '0);
        flags.hw_full     = (hw_reg == LAST);
    end

    assign status     = out_st_reg;
    assign node_index = 8'(out_idx_reg);
    assign data_out   = out_data_reg;

`ifndef SYNTHESIS
    a_fh_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        fh_reg <= hw_reg) else $error("free head beyond high-water mark");
    a_head_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= hw_reg) else $error("head beyond high-water mark");
    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= hw_reg) else $error("current node beyond high-water mark");
`endif

endmodule

// ----- hw/rtl/alle_ctrl.sv -----
module alle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        action,
    output logic              out_valid,
    input  logic              out_ready,
    output alle_pkg::cmd_t    cmd,
    input  alle_pkg::flags_t  flags
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_INS_WR,
        S_INS_PRIME,
        S_INS_WALK,
        S_RF,
        S_RR_WALK,
        S_RC_WALK,
        S_RC_LINK,
        S_SR_WALK,
        S_RT_WALK,
        S_PG_SK,
        S_PG_NX,
        S_PG_RDS,
        S_PG_SN,
        S_CLR,
        S_FETCH,
        S_FETCH_Q,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    alle_pkg::act_t    act_reg;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = alle_pkg::OP_NOP;
        cmd.st         = alle_pkg::ST_OK;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = alle_pkg::OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FETCH;
                cmd.op     = alle_pkg::OP_RES;
                cmd.st     = alle_pkg::ST_EMPTY;
                unique case (act_reg)
                    alle_pkg::ACT_INS_FRONT, alle_pkg::ACT_INS_REAR:
                    begin
                        priority if (!flags.fh_zero)
                        begin
                            cmd.op     = alle_pkg::OP_ALLOC_FREE;
                            state_next = S_POP;
                        end
                        else if (!flags.hw_full)
                        begin
                            cmd.op     = alle_pkg::OP_ALLOC_HW;
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            cmd.st = alle_pkg::ST_FULL;
                        end
                    end
                    alle_pkg::ACT_RM_FRONT:
                    begin
                        if (!flags.head_zero)
                        begin
                            cmd.op     = alle_pkg::OP_PRIME;
                            state_next = S_RF;
                        end
                    end
                    alle_pkg::ACT_RM_REAR:
                    begin
                        if (!flags.head_zero)
                        begin
                            cmd.op     = alle_pkg::OP_PRIME;
                            state_next = S_RR_WALK;
                        end
                    end
                    alle_pkg::ACT_RM_CUR:
                    begin
                        priority if (flags.head_zero)
                        begin
                            cmd.st = alle_pkg::ST_EMPTY;
                        end
                        else if (flags.cur_zero)
                        begin
                            cmd.st = alle_pkg::ST_NOCUR;
                        end
                        else if (flags.cur_is_head)
                        begin
                            cmd.op     = alle_pkg::OP_PRIME;
                            state_next = S_RF;
                        end
                        else
                        begin
                            cmd.op     = alle_pkg::OP_PRIME;
                            state_next = S_RC_WALK;
                        end
                    end
                    alle_pkg::ACT_SEARCH:
                    begin
                        cmd.op     = alle_pkg::OP_PRIME;
                        state_next = S_SR_WALK;
                    end
                    alle_pkg::ACT_RETRIEVE:
                    begin
                        cmd.op     = alle_pkg::OP_PRIME;
                        state_next = S_RT_WALK;
                    end
                    alle_pkg::ACT_PURGE:
                    begin
                        if (!flags.head_zero)
                        begin
                            cmd.op     = alle_pkg::OP_PG_START;
                            state_next = S_PG_SK;
                        end
                    end
                    alle_pkg::ACT_CLEAR:
                    begin
                        cmd.op     = alle_pkg::OP_NOP;
                        state_next = S_CLR;
                    end
                    alle_pkg::ACT_READ_CUR:
                    begin
                        if (flags.cur_zero)
                        begin
                            cmd.st = alle_pkg::ST_NOCUR;
                        end
                        else
                        begin
                            cmd.op = alle_pkg::OP_RES_CUR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP:
            begin
                cmd.op     = alle_pkg::OP_POP;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                if (act_reg == alle_pkg::ACT_INS_FRONT || flags.head_zero)
                begin
                    cmd.op     = alle_pkg::OP_INS_WR_FRONT;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_INS_WR_REAR;
                    state_next = S_INS_PRIME;
                end
            end
            S_INS_PRIME:
            begin
                cmd.op     = alle_pkg::OP_PRIME;
                state_next = S_INS_WALK;
            end
            S_INS_WALK:
            begin
                if (flags.link_zero)
                begin
                    cmd.op     = alle_pkg::OP_ATTACH;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op = alle_pkg::OP_STEP;
                end
            end
            S_RF:
            begin
                cmd.op     = alle_pkg::OP_RF;
                state_next = (act_reg == alle_pkg::ACT_CLEAR) ? S_CLR : S_FETCH;
            end
            S_RR_WALK:
            begin
                priority if (!flags.link_zero)
                begin
                    cmd.op = alle_pkg::OP_STEP;
                end
                else if (flags.pre_zero)
                begin
                    // single node: same as removing the head
                    cmd.op     = alle_pkg::OP_RF;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_RR_END;
                    state_next = S_FETCH;
                end
            end
            S_RC_WALK:
            begin
                priority if (flags.link_is_cur)
                begin
                    cmd.op     = alle_pkg::OP_RC_RD;
                    state_next = S_RC_LINK;
                end
                else if (flags.link_zero)
                begin
                    cmd.op     = alle_pkg::OP_RES;
                    cmd.st     = alle_pkg::ST_NOCUR;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op = alle_pkg::OP_STEP;
                end
            end
            S_RC_LINK:
            begin
                cmd.op     = alle_pkg::OP_RC_LINK;
                state_next = S_FETCH;
            end
            S_SR_WALK:
            begin
                priority if (flags.p_zero)
                begin
                    cmd.op     = alle_pkg::OP_RES;
                    cmd.st     = alle_pkg::ST_EMPTY;
                    state_next = S_FETCH;
                end
                else if (flags.same)
                begin
                    cmd.op     = alle_pkg::OP_FOUND;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op = alle_pkg::OP_STEP;
                end
            end
            S_RT_WALK:
            begin
                priority if (flags.p_zero)
                begin
                    cmd.op     = alle_pkg::OP_RES;
                    cmd.st     = alle_pkg::ST_EMPTY;
                    state_next = S_FETCH;
                end
                else if (flags.pos_zero)
                begin
                    cmd.op     = alle_pkg::OP_FOUND;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op = alle_pkg::OP_STEP;
                end
            end
            S_PG_SK:
            begin
                cmd.op     = alle_pkg::OP_PG_KEY;
                state_next = flags.link_zero ? S_PG_RDS : S_PG_NX;
            end
            S_PG_NX:
            begin
                cmd.op     = flags.same ? alle_pkg::OP_PG_DROP : alle_pkg::OP_PG_KEEP;
                state_next = flags.link_zero ? S_PG_RDS : S_PG_NX;
            end
            S_PG_RDS:
            begin
                cmd.op     = alle_pkg::OP_PG_RDS;
                state_next = S_PG_SN;
            end
            S_PG_SN:
            begin
                if (flags.link_zero)
                begin
                    cmd.op     = alle_pkg::OP_PG_END;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_PG_ADV;
                    state_next = S_PG_SK;
                end
            end
            S_CLR:
            begin
                if (flags.head_zero)
                begin
                    cmd.op     = alle_pkg::OP_CLR_END;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_PRIME;
                    state_next = S_RF;
                end
            end
            S_FETCH:
            begin
                cmd.op     = alle_pkg::OP_FETCH;
                state_next = S_FETCH_Q;
            end
            S_FETCH_Q:
            begin
                cmd.op     = alle_pkg::OP_FETCH_Q;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = alle_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= alle_pkg::ACT_INS_FRONT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_IDLE && in_valid)
            begin
                act_reg <= alle_pkg::act_t'(action);
            end
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second transaction taken early");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && !out_ready |=> state_reg == S_OUT)
        else $error("pending result overwritten");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == alle_pkg::OP_OUT |=> out_valid_reg) else $error("result load lost valid");
`endif

endmodule

// ----- hw/rtl/array_linked_list_engine.sv -----
// Linked-list engine over a fixed node store (slot 0 means none).
// Input channel: in_valid/in_ready carry action, data_in and position.
// Output channel: out_valid/out_ready carry status, node_index, data_out;
// exactly one result per input transaction, in order.
// cfg_write/cfg_data load compare_mask (bits compared by search and purge);
// write it only while the engine is idle.
// One transaction is processed at a time. Rear insert, remove rear, remove
// current (when it is not the head), search and retrieve walk the list,
// one node per cycle through the link memory read port; clear removes the
// head node again and again until the list is empty, and purge runs a
// nested walk. A new transaction is taken only after the previous result
// has been loaded into the output register.
// A finished result sits in an output register; a new transaction is taken
// while it waits, but the next result is held until the receiver takes it.
// Reset empties the list, free list and high-water mark and sets
// compare_mask to all ones; the node memories are not cleared.
module array_linked_list_engine #(
    parameter int NODES     = 256,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           action,
    input  logic [DATA_BITS-1:0] data_in,
    input  logic [7:0]           position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [7:0]           node_index,
    output logic [DATA_BITS-1:0] data_out,
    input  logic                 cfg_write,
    input  logic [DATA_BITS-1:0] cfg_data
);

    alle_pkg::cmd_t   cmd;
    alle_pkg::flags_t flags;

    alle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .flags     (flags)
    );

    alle_dpath #(
        .NODES     (NODES),
        .DATA_BITS (DATA_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .flags      (flags),
        .data_in    (data_in),
        .position   (position),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .status     (status),
        .node_index (node_index),
        .data_out   (data_out)
    );

endmodule
